// ===== src/rosl_pkg.sv =====
// ----------------------------------------------------------------------------
// rosl_pkg: shared types and constants for the ray / oriented box slab test
// Register map, control sideband of the divider chain, fixed constants.
// ----------------------------------------------------------------------------
package rosl_pkg;

  localparam int REG_W     = 60;  // width of every configuration register
  localparam int REG_IDX_W = 3;
  localparam int NUM_DIV   = 6;   // two plane distances for each of three axes
  localparam longint T_FAR_UNITS = 64'd100000;  // far end of the ray interval

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_AXIS      = 3'd0,
    REG_Y_AXIS      = 3'd1,
    REG_Z_AXIS      = 3'd2,
    REG_POSITION    = 3'd3,
    REG_LOW_CORNER  = 3'd4,
    REG_HIGH_CORNER = 3'd5
  } reg_idx_e;

  // sideband that rides along with the divider data
  typedef struct packed {
    logic                 valid;
    logic [2:0]           nonpar;  // axis is not parallel: use its distances
    logic                 pmiss;   // some parallel axis puts the origin off its slab
    logic [NUM_DIV-1:0]   neg;     // quotient sign per divider lane
  } ctl_t;

endpackage

// ===== src/rosl_div_cell.sv =====
// ----------------------------------------------------------------------------
// rosl_div_cell: one restoring division step for all divider lanes
// Consumes one dividend bit per lane, shifts one quotient bit in, registers.
// ----------------------------------------------------------------------------
module rosl_div_cell #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 42
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  rosl_pkg::ctl_t                          ctl_i,
  input  logic [rosl_pkg::NUM_DIV-1:0][NUM_W-1:0] nq_i,
  input  logic [rosl_pkg::NUM_DIV-1:0][DEN_W-1:0] rem_i,
  input  logic [rosl_pkg::NUM_DIV-1:0][DEN_W-1:0] den_i,
  output rosl_pkg::ctl_t                          ctl_o,
  output logic [rosl_pkg::NUM_DIV-1:0][NUM_W-1:0] nq_o,
  output logic [rosl_pkg::NUM_DIV-1:0][DEN_W-1:0] rem_o,
  output logic [rosl_pkg::NUM_DIV-1:0][DEN_W-1:0] den_o
);

  rosl_pkg::ctl_t                          ctl_q;
  logic [rosl_pkg::NUM_DIV-1:0][NUM_W-1:0] nq_d, nq_q;
  logic [rosl_pkg::NUM_DIV-1:0][DEN_W-1:0] rem_d, rem_q, den_q;
  logic [DEN_W:0] trial [rosl_pkg::NUM_DIV];
  logic [DEN_W:0] diff  [rosl_pkg::NUM_DIV];
  logic           ge    [rosl_pkg::NUM_DIV];

  always_comb begin
    for (int j = 0; j < rosl_pkg::NUM_DIV; j++) begin
      trial[j] = {rem_i[j], nq_i[j][NUM_W-1]};
      diff[j]  = trial[j] - {1'b0, den_i[j]};
      ge[j]    = trial[j] >= {1'b0, den_i[j]};
      rem_d[j] = ge[j] ? diff[j][DEN_W-1:0] : trial[j][DEN_W-1:0];
      nq_d[j]  = {nq_i[j][NUM_W-2:0], ge[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q  <= nq_d;
      rem_q <= rem_d;
      den_q <= den_i;
    end
  end

  assign ctl_o = ctl_q;
  assign nq_o  = nq_q;
  assign rem_o = rem_q;
  assign den_o = den_q;

endmodule

// ===== src/rosl_axis_front.sv =====
// ----------------------------------------------------------------------------
// rosl_axis_front: per-axis dot products and divider operands
// Three stages: products, sums, then numerator / divisor magnitudes and flags.
// ----------------------------------------------------------------------------
module rosl_axis_front #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 12,
  localparam int E_W   = 2*COORD_WIDTH + 3,
  localparam int F_W   = 2*COORD_WIDTH + 2,
  localparam int SUM_W = ((E_W > COORD_WIDTH + FRAC_BITS) ? E_W
                                                          : COORD_WIDTH + FRAC_BITS) + 1,
  localparam int NUM_W = SUM_W + FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [2:0][COORD_WIDTH-1:0] ax_i,
  input  logic [2:0][COORD_WIDTH:0]   delta_i,
  input  logic [2:0][COORD_WIDTH-1:0] dir_i,
  input  logic [COORD_WIDTH-1:0]      lo_i,
  input  logic [COORD_WIDTH-1:0]      hi_i,
  output logic [NUM_W-1:0]            num_lo_o,
  output logic [NUM_W-1:0]            num_hi_o,
  output logic [F_W-1:0]              den_o,
  output logic                        neg_lo_o,
  output logic                        neg_hi_o,
  output logic                        nonpar_o,
  output logic                        pmiss_o
);

  localparam int PW = (F_W > 64) ? F_W : 64;
  localparam logic [PW-1:0] PAR_LIMIT = PW'((64'd1 << (2*FRAC_BITS)) / 64'd1000);

  logic signed [2*COORD_WIDTH:0]   pe_d [3], pe_q [3];
  logic signed [2*COORD_WIDTH-1:0] pf_d [3], pf_q [3];
  logic signed [E_W-1:0]           e_q;
  logic signed [F_W-1:0]           f_q;

  logic signed [SUM_W-1:0] lo_s, hi_s, e_s, s_lo, s_hi;
  logic [SUM_W-1:0]        mag_lo, mag_hi;
  logic [F_W-1:0]          fmag;
  logic                    fneg, nonpar;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pe_d[k] = $signed(ax_i[k]) * $signed(delta_i[k]);
      pf_d[k] = $signed(dir_i[k]) * $signed(ax_i[k]);
    end
  end

  always_comb begin
    lo_s   = $signed({{(SUM_W-COORD_WIDTH){lo_i[COORD_WIDTH-1]}}, lo_i}) <<< FRAC_BITS;
    hi_s   = $signed({{(SUM_W-COORD_WIDTH){hi_i[COORD_WIDTH-1]}}, hi_i}) <<< FRAC_BITS;
    e_s    = SUM_W'(e_q);
    s_lo   = e_s + lo_s;
    s_hi   = e_s + hi_s;
    mag_lo = s_lo[SUM_W-1] ? -s_lo : s_lo;
    mag_hi = s_hi[SUM_W-1] ? -s_hi : s_hi;
    fneg   = f_q[F_W-1];
    fmag   = fneg ? -f_q : f_q;
    nonpar = PW'(fmag) > PAR_LIMIT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pe_q     <= pe_d;
      pf_q     <= pf_d;
      e_q      <= E_W'(pe_q[0]) + E_W'(pe_q[1]) + E_W'(pe_q[2]);
      f_q      <= F_W'(pf_q[0]) + F_W'(pf_q[1]) + F_W'(pf_q[2]);
      num_lo_o <= {mag_lo, {FRAC_BITS{1'b0}}};
      num_hi_o <= {mag_hi, {FRAC_BITS{1'b0}}};
      den_o    <= fmag;
      neg_lo_o <= s_lo[SUM_W-1] ^ fneg;
      neg_hi_o <= s_hi[SUM_W-1] ^ fneg;
      nonpar_o <= nonpar;
      // parallel axis: origin must lie inside the slab
      pmiss_o  <= !nonpar && ((lo_s > e_s) || (hi_s < e_s));
    end
  end

endmodule

// ===== src/ray_obb_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_obb_slab_test: ray versus oriented box slab test, fully pipelined
// Input channel (in_valid_i / in_stall_o) carries one ray per transaction:
// origin and direction, signed fixed point with FRAC_BITS fraction bits.
// Output channel (out_valid_o / out_stall_i) returns hit_o and entry_distance_o
// (near bound of the interval, 0 on a miss, saturated to DIST_WIDTH bits).
// The user must set the box through cfg_we_i / cfg_idx_i / cfg_data_i only
// while idle; the block does not enforce this. Throughput: one ray per cycle
// while the output is not stalled. Stages: one input stage, three dot-product
// stages, one restoring division cell per dividend bit (NUM_W, the dividend
// width), and four stages of interval logic with the output register.
// When out_stall_i holds a valid result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is dropped.
// Reset clears all valid bits and loads unit axes, zero position and corners.
// ----------------------------------------------------------------------------
module ray_obb_slab_test #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 12,
  parameter int DIST_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rosl_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rosl_pkg::REG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]       origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]       origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]       dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [DIST_WIDTH-1:0]        entry_distance_o
);

  localparam int W     = COORD_WIDTH;
  localparam int E_W   = 2*W + 3;
  localparam int F_W   = 2*W + 2;
  localparam int SUM_W = ((E_W > W + FRAC_BITS) ? E_W : W + FRAC_BITS) + 1;
  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int QW    = NUM_W + 1;
  localparam int CMP_W = (QW > DIST_WIDTH) ? QW : DIST_WIDTH + 1;
  localparam int ND    = rosl_pkg::NUM_DIV;
  localparam logic signed [QW-1:0] T_FAR =
      QW'(64'(rosl_pkg::T_FAR_UNITS) << FRAC_BITS);
  localparam logic signed [CMP_W-1:0] DMAX = (CMP_W'(1) <<< (DIST_WIDTH-1)) - 1;

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // configuration registers
  logic [rosl_pkg::REG_W-1:0]      cfg_q [6];
  logic [rosl_pkg::REG_W+3*W-1:0]  wide  [6];
  logic [W-1:0]                    lanes [6][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        cfg_q[i] <= (i < 3) ? rosl_pkg::REG_W'(1) << (FRAC_BITS + i*W) : '0;
      end
    end else if (cfg_we_i) begin
      case (rosl_pkg::reg_idx_e'(cfg_idx_i))
        rosl_pkg::REG_X_AXIS:      cfg_q[0] <= cfg_data_i;
        rosl_pkg::REG_Y_AXIS:      cfg_q[1] <= cfg_data_i;
        rosl_pkg::REG_Z_AXIS:      cfg_q[2] <= cfg_data_i;
        rosl_pkg::REG_POSITION:    cfg_q[3] <= cfg_data_i;
        rosl_pkg::REG_LOW_CORNER:  cfg_q[4] <= cfg_data_i;
        rosl_pkg::REG_HIGH_CORNER: cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // lanes beyond the register's top bits read as zero
  always_comb begin
    for (int r = 0; r < 6; r++) begin
      wide[r] = {{(3*W){1'b0}}, cfg_q[r]};
      for (int k = 0; k < 3; k++) begin
        lanes[r][k] = wide[r][k*W +: W];
      end
    end
  end

  // input stage
  logic [2:0][W-1:0] org, delta_n, dir_d, dir_q;
  logic [2:0][W:0]   delta_d, delta_q;
  logic [3:0]        vf_q;

  assign org   = {origin_z_i, origin_y_i, origin_x_i};
  assign dir_d = {dir_z_i, dir_y_i, dir_x_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta_n[k] = lanes[3][k];
      delta_d[k] = {delta_n[k][W-1], delta_n[k]} - {org[k][W-1], org[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      delta_q <= delta_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else if (en) begin
      vf_q <= {vf_q[2:0], in_valid_i};
    end
  end

  // per-axis front end
  logic [NUM_W-1:0] num_lo [3], num_hi [3];
  logic [F_W-1:0]   den    [3];
  logic [2:0]       neg_lo, neg_hi, nonpar, pmiss;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rosl_axis_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_front (
      .clk_i    (clk_i),
      .en_i     (en),
      .ax_i     ({lanes[a][2], lanes[a][1], lanes[a][0]}),
      .delta_i  (delta_q),
      .dir_i    (dir_q),
      .lo_i     (lanes[4][a]),
      .hi_i     (lanes[5][a]),
      .num_lo_o (num_lo[a]),
      .num_hi_o (num_hi[a]),
      .den_o    (den[a]),
      .neg_lo_o (neg_lo[a]),
      .neg_hi_o (neg_hi[a]),
      .nonpar_o (nonpar[a]),
      .pmiss_o  (pmiss[a])
    );
  end

  // divider chain: lane 2a is the low plane of axis a, lane 2a+1 the high plane
  rosl_pkg::ctl_t                ctl_c [NUM_W+1];
  logic [ND-1:0][NUM_W-1:0]      nq_c  [NUM_W+1];
  logic [ND-1:0][F_W-1:0]        rem_c [NUM_W+1];
  logic [ND-1:0][F_W-1:0]        den_c [NUM_W+1];

  always_comb begin
    ctl_c[0].valid  = vf_q[3];
    ctl_c[0].nonpar = nonpar;
    ctl_c[0].pmiss  = |pmiss;
    for (int a = 0; a < 3; a++) begin
      ctl_c[0].neg[2*a]   = neg_lo[a];
      ctl_c[0].neg[2*a+1] = neg_hi[a];
      nq_c[0][2*a]        = num_lo[a];
      nq_c[0][2*a+1]      = num_hi[a];
      den_c[0][2*a]       = den[a];
      den_c[0][2*a+1]     = den[a];
    end
    rem_c[0] = '0;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    rosl_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (F_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[i]),
      .nq_i   (nq_c[i]),
      .rem_i  (rem_c[i]),
      .den_i  (den_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .nq_o   (nq_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .den_o  (den_c[i+1])
    );
  end

  // back end: signs, per-axis ordering, interval reduction, output
  rosl_pkg::ctl_t           ctl_b1_q;
  logic signed [QW-1:0]     t_d [ND], t_q [ND];
  logic signed [QW-1:0]     cmin_d [3], cmax_d [3], cmin_q [3], cmax_q [3];
  logic signed [QW-1:0]     m01, m2, n01, n2, tmin_d, tmax_d, tmin_q, tmax_q;
  logic                     v2_q, pm2_q, v3_q, pm3_q, out_valid_q, hit_q;
  logic signed [CMP_W-1:0]  tmin_x;
  logic                     hit_d;
  logic signed [DIST_WIDTH-1:0] dist_d, dist_q;

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      t_d[j] = ctl_c[NUM_W].neg[j] ? -$signed({1'b0, nq_c[NUM_W][j]})
                                   :  $signed({1'b0, nq_c[NUM_W][j]});
    end
    for (int a = 0; a < 3; a++) begin
      if (!ctl_b1_q.nonpar[a]) begin
        cmin_d[a] = '0;
        cmax_d[a] = T_FAR;
      end else if (t_q[2*a] > t_q[2*a+1]) begin
        cmin_d[a] = t_q[2*a+1];
        cmax_d[a] = t_q[2*a];
      end else begin
        cmin_d[a] = t_q[2*a];
        cmax_d[a] = t_q[2*a+1];
      end
    end
    m01    = (cmin_q[0] > cmin_q[1]) ? cmin_q[0] : cmin_q[1];
    m2     = (cmin_q[2] > 0) ? cmin_q[2] : '0;
    tmin_d = (m01 > m2) ? m01 : m2;
    n01    = (cmax_q[0] < cmax_q[1]) ? cmax_q[0] : cmax_q[1];
    n2     = (cmax_q[2] < T_FAR) ? cmax_q[2] : T_FAR;
    tmax_d = (n01 < n2) ? n01 : n2;
    // tmin is never negative, so only the upper bound can saturate
    tmin_x = CMP_W'(tmin_q);
    hit_d  = !pm3_q && (tmax_q >= tmin_q);
    if (!hit_d) begin
      dist_d = '0;
    end else if (tmin_x > DMAX) begin
      dist_d = DIST_WIDTH'(DMAX);
    end else begin
      dist_d = DIST_WIDTH'(tmin_x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= t_d;
      cmin_q <= cmin_d;
      cmax_q <= cmax_d;
      tmin_q <= tmin_d;
      tmax_q <= tmax_d;
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b1_q    <= '0;
      v2_q        <= 1'b0;
      pm2_q       <= 1'b0;
      v3_q        <= 1'b0;
      pm3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ctl_b1_q    <= ctl_c[NUM_W];
      v2_q        <= ctl_b1_q.valid;
      pm2_q       <= ctl_b1_q.pmiss;
      v3_q        <= v2_q;
      pm3_q       <= pm2_q;
      out_valid_q <= v3_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign entry_distance_o = dist_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !hit_o |-> entry_distance_o == '0)
    else $error("miss with nonzero entry distance");

  a_dist_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> !entry_distance_o[DIST_WIDTH-1])
    else $error("negative entry distance");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_front_to_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
      en && vf_q[3] |=> ctl_c[1].valid)
    else $error("front-end transaction lost entering divider chain");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ray / oriented box slab test
// Sends rays with random gaps and back-pressure, predicts hit and entry
// distance with a behavioral slab test, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW   = 20;
  localparam int FB   = 12;
  localparam int DW   = 32;
  localparam int UNIT = 1 << FB;
  localparam int PIPE_DRAIN = 100;  // comfortably above the depth of the DUT pipeline
  localparam longint PAR_LIMIT = (64'sd1 <<< (2 * FB)) / 1000;
  localparam longint T_FAR = 64'sd100000 * UNIT;
  localparam logic [rosl_pkg::REG_IDX_W-1:0] IDX_UNUSED = 3'd6;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic                 hit;
    logic signed [DW-1:0] dist_val;
  } slab_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [rosl_pkg::REG_IDX_W-1:0] cfg_idx = rosl_pkg::REG_X_AXIS;
  logic [rosl_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] org_x = '0, org_y = '0, org_z = '0;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic signed [DW-1:0] entry_dist;

  logic [rosl_pkg::REG_W-1:0] box_reg [6];
  slab_result_t hit_queue[$];
  int errors = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  int hold_left = 0;

  always #1 clk_i = ~clk_i;

  ray_obb_slab_test #(.COORD_WIDTH(CW), .FRAC_BITS(FB), .DIST_WIDTH(DW)) dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .origin_x_i(org_x), .origin_y_i(org_y), .origin_z_i(org_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_o(hit), .entry_distance_o(entry_dist)
  );

  function automatic longint lane_of(logic [rosl_pkg::REG_W-1:0] r, int k);
    logic signed [CW-1:0] v;
    v = r[k*CW +: CW];
    return longint'(v);
  endfunction

  function automatic slab_result_t slab_predict(ray_t r);
    longint org[3], dir[3], delta[3];
    longint e, f, lo, hi, af, t1, t2, tmp, ax;
    longint tmin, tmax, d;
    bit is_hit;
    slab_result_t res;
    org = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
    dir = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
    tmin = 0;
    tmax = T_FAR;
    is_hit = 1;
    for (int k = 0; k < 3; k++)
      delta[k] = lane_of(box_reg[rosl_pkg::REG_POSITION], k) - org[k];
    for (int a = 0; a < 3 && is_hit; a++) begin
      e = 0;
      f = 0;
      for (int k = 0; k < 3; k++) begin
        ax = lane_of(box_reg[a], k);
        e += ax * delta[k];
        f += dir[k] * ax;
      end
      lo = lane_of(box_reg[rosl_pkg::REG_LOW_CORNER], a) * UNIT;
      hi = lane_of(box_reg[rosl_pkg::REG_HIGH_CORNER], a) * UNIT;
      af = (f < 0) ? -f : f;
      if (af > PAR_LIMIT) begin
        t1 = ((e + lo) * UNIT) / f;
        t2 = ((e + hi) * UNIT) / f;
        if (t1 > t2) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        if (t2 < tmax) tmax = t2;
        if (t1 > tmin) tmin = t1;
        if (tmax < tmin) is_hit = 0;
      end else if (lo - e > 0 || hi - e < 0) begin
        is_hit = 0;
      end
    end
    d = is_hit ? tmin : 0;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    res.hit = is_hit;
    res.dist_val = d[DW-1:0];
    return res;
  endfunction

  // receiver: random stalls, forced hold-off, or quiet stretch
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    slab_result_t exp_res;
    if (rst_ni && out_valid && !out_stall) begin
      if (hit_queue.size() == 0) begin
        $error("unexpected result transaction: hit=%0d dist=%0d", hit, entry_dist);
        errors++;
      end else begin
        exp_res = hit_queue.pop_front();
        if (hit !== exp_res.hit) begin
          $error("hit: expected %0d, actual %0d", exp_res.hit, hit);
          errors++;
        end
        if (entry_dist !== exp_res.dist_val) begin
          $error("entry_distance: expected %0d, actual %0d", exp_res.dist_val, entry_dist);
          errors++;
        end
      end
    end
  end

  task automatic send_ray(ray_t r);
    @(negedge clk_i);
    if (!tx_quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    org_x <= r.ox; org_y <= r.oy; org_z <= r.oz;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    hit_queue.push_back(slab_predict(r));
  endtask

  // idle the sender and wait until every result is back and the pipe is empty
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (hit_queue.size() == 0);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [rosl_pkg::REG_IDX_W-1:0] idx,
                           logic [rosl_pkg::REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx <= rosl_pkg::REG_HIGH_CORNER) box_reg[idx] = data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [rosl_pkg::REG_W-1:0] pack3(longint x, longint y, longint z);
    logic [CW-1:0] a, b, c;
    a = x[CW-1:0]; b = y[CW-1:0]; c = z[CW-1:0];
    return {c, b, a};
  endfunction

  function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = ox[CW-1:0]; r.oy = oy[CW-1:0]; r.oz = oz[CW-1:0];
    r.dx = dx[CW-1:0]; r.dy = dy[CW-1:0]; r.dz = dz[CW-1:0];
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // ray aimed near the box center, with some near-parallel components
  function automatic ray_t aimed_ray();
    longint tgt[3], off[3], dir[3];
    for (int k = 0; k < 3; k++) begin
      tgt[k] = lane_of(box_reg[rosl_pkg::REG_POSITION], k)
               + $signed($urandom_range(0, 8 * UNIT)) - 4 * UNIT;
      off[k] = $signed($urandom_range(0, 120 * UNIT)) - 60 * UNIT;
      dir[k] = -off[k];
      case ($urandom_range(19))
        0: dir[k] = 0;
        1: dir[k] = $signed($urandom_range(0, 12)) - 6;
        2: dir[k] = dir[k] >>> $urandom_range(1, 8);
        default: ;
      endcase
    end
    return make_ray(tgt[0] + off[0], tgt[1] + off[1], tgt[2] + off[2],
                    dir[0], dir[1], dir[2]);
  endfunction

  function automatic longint rnd_units(int span);
    return $signed($urandom_range(0, 2 * span * UNIT)) - span * UNIT;
  endfunction

  function automatic longint rnd_whole(int lo_u, int hi_u);
    return longint'($urandom_range(lo_u, hi_u)) * UNIT;
  endfunction

  // box with axes permuted / flipped or rotated 45 degrees in one plane
  task automatic load_shaped_box();
    longint c45;
    int p;
    c45 = 2896;
    p = $urandom_range(3);
    drain_pipe();
    if (p == 3) begin
      cfg_write(rosl_pkg::REG_X_AXIS, pack3(c45, c45, 0));
      cfg_write(rosl_pkg::REG_Y_AXIS, pack3(-c45, c45, 0));
      cfg_write(rosl_pkg::REG_Z_AXIS, pack3(0, 0, $urandom_range(1) ? UNIT : -UNIT));
    end else begin
      cfg_write(rosl_pkg::REG_X_AXIS,
                pack3(p == 0 ? UNIT : 0, p == 1 ? -UNIT : 0, p == 2 ? UNIT : 0));
      cfg_write(rosl_pkg::REG_Y_AXIS,
                pack3(p == 2 ? -UNIT : 0, p == 0 ? UNIT : 0, p == 1 ? UNIT : 0));
      cfg_write(rosl_pkg::REG_Z_AXIS,
                pack3(p == 1 ? UNIT : 0, p == 2 ? UNIT : 0, p == 0 ? -UNIT : 0));
    end
    cfg_write(rosl_pkg::REG_POSITION, pack3(rnd_units(50), rnd_units(50), rnd_units(50)));
    cfg_write(rosl_pkg::REG_LOW_CORNER, pack3(-rnd_whole(0, 20), -rnd_whole(0, 20),
                                              -rnd_whole(0, 20)));
    // occasionally swapped corners
    if ($urandom_range(7) == 0)
      cfg_write(rosl_pkg::REG_HIGH_CORNER,
                pack3(-rnd_whole(0, 5), rnd_whole(0, 20), -3 * UNIT));
    else
      cfg_write(rosl_pkg::REG_HIGH_CORNER, pack3(rnd_whole(1, 20), rnd_whole(1, 20),
                                                 rnd_whole(1, 20)));
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = (1 <<< (CW - 1)) - 1;
    mn = -(1 <<< (CW - 1));
    // reset box: unit axes, a point at the origin
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(mx, mx, mx, mx, mx, mx));
    send_ray(make_ray(mn, mn, mn, mn, mn, mn));
    send_ray(make_ray(mx, mn, mx, mn, mx, mn));
    send_ray(make_ray(-UNIT, 0, 0, UNIT, 0, 0));
    drain_pipe();
    cfg_write(rosl_pkg::REG_LOW_CORNER, pack3(-2 * UNIT, -2 * UNIT, -2 * UNIT));
    cfg_write(rosl_pkg::REG_HIGH_CORNER, pack3(2 * UNIT, 2 * UNIT, 2 * UNIT));
    cfg_write(IDX_UNUSED, '1);  // out of range, dropped
    send_ray(make_ray(-10 * UNIT, 0, 0, UNIT, 0, 0));        // hit, y/z parallel
    send_ray(make_ray(-10 * UNIT, 5 * UNIT, 0, UNIT, 0, 0)); // parallel miss on y
    send_ray(make_ray(10 * UNIT, 0, 0, UNIT, 0, 0));         // box behind
    send_ray(make_ray(0, 0, 0, UNIT, UNIT, UNIT));           // origin inside
    send_ray(make_ray(-10 * UNIT, 0, 0, 4, 0, 0));           // just at parallel limit
    send_ray(make_ray(-10 * UNIT, 0, 0, 5, 0, 0));
    send_ray(make_ray(-10 * UNIT, -10 * UNIT, 3 * UNIT, UNIT, UNIT, 0));
    send_ray(make_ray(-100 * UNIT, 0, 0, 1 <<< 18, 0, 0));
    drain_pipe();
    cfg_write(rosl_pkg::REG_LOW_CORNER, pack3(2 * UNIT, 2 * UNIT, 2 * UNIT));  // swapped
    cfg_write(rosl_pkg::REG_HIGH_CORNER, pack3(-2 * UNIT, -2 * UNIT, -2 * UNIT));
    send_ray(make_ray(-10 * UNIT, 0, 0, UNIT, 0, 0));
    send_ray(make_ray(-10 * UNIT, -9 * UNIT, -8 * UNIT, UNIT, UNIT, UNIT));
    drain_pipe();
    cfg_write(rosl_pkg::REG_X_AXIS, '0);  // degenerate axis
    send_ray(make_ray(0, 0, 0, UNIT, 0, 0));
    send_ray(make_ray(-3 * UNIT, 0, 0, UNIT, 0, 0));
  endtask

  task automatic test_shaped_boxes(int n_boxes, int per_box);
    for (int b = 0; b < n_boxes; b++) begin
      load_shaped_box();
      for (int i = 0; i < per_box; i++)
        send_ray($urandom_range(9) < 8 ? aimed_ray() : noise_ray());
    end
  endtask

  task automatic test_random_registers(int n);
    drain_pipe();
    for (int r = rosl_pkg::REG_X_AXIS; r <= rosl_pkg::REG_HIGH_CORNER; r++)
      cfg_write(rosl_pkg::reg_idx_e'(r), {$urandom, $urandom});
    for (int i = 0; i < n; i++) send_ray($urandom_range(1) ? aimed_ray() : noise_ray());
  endtask

  task automatic test_extreme_registers(int n);
    drain_pipe();
    for (int r = rosl_pkg::REG_X_AXIS; r <= rosl_pkg::REG_HIGH_CORNER; r++)
      cfg_write(rosl_pkg::reg_idx_e'(r), '1);
    for (int i = 0; i < n; i++) send_ray(noise_ray());
    drain_pipe();
    for (int r = rosl_pkg::REG_X_AXIS; r <= rosl_pkg::REG_HIGH_CORNER; r++)
      cfg_write(rosl_pkg::reg_idx_e'(r),
                pack3(-(1 <<< (CW - 1)), (1 <<< (CW - 1)) - 1, -(1 <<< (CW - 1))));
    for (int i = 0; i < n; i++) send_ray(noise_ray());
  endtask

  task automatic test_no_idle(int n);
    load_shaped_box();
    tx_quiet = 1;
    rx_quiet = 1;
    for (int i = 0; i < n; i++) send_ray(aimed_ray());
    tx_quiet = 0;
    rx_quiet = 0;
  endtask

  // receiver holds off long enough that the pipe fills and stalls the input
  task automatic test_backpressure(int n);
    load_shaped_box();
    tx_quiet = 1;
    hold_left = 300;
    for (int i = 0; i < n; i++) send_ray(aimed_ray());
    tx_quiet = 0;
  endtask

  initial begin
    for (int r = 0; r < 6; r++) box_reg[r] = '0;
    box_reg[rosl_pkg::REG_X_AXIS] = pack3(UNIT, 0, 0);
    box_reg[rosl_pkg::REG_Y_AXIS] = pack3(0, UNIT, 0);
    box_reg[rosl_pkg::REG_Z_AXIS] = pack3(0, 0, UNIT);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_shaped_boxes(12, 50);
    test_no_idle(150);
    test_backpressure(150);
    test_random_registers(60);
    test_extreme_registers(30);
    test_shaped_boxes(4, 40);
    drain_pipe();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rosl_pkg.sv
src/rosl_div_cell.sv
src/rosl_axis_front.sv
src/ray_obb_slab_test.sv
sim/testbench.sv
